FILE: src/escf_pkg.sv
// ----------------------------------------------------------------------------
// escf_pkg: shared types and constants of the speed command framer
// Holds the request and result payload structs, command codes and the
// channel to slot map.
// ----------------------------------------------------------------------------
package escf_pkg;

  localparam int unsigned PER_W  = 12;
  localparam int unsigned SPD_W  = 14;
  localparam int unsigned MOTORS = 4;

  localparam logic [7:0] CMD_SPEED = 8'h02;
  localparam logic [7:0] CMD_START = 8'h40;
  localparam logic [7:0] CMD_STOP  = 8'h60;
  localparam logic [7:0] CMD_CLEAR = 8'h80;

  localparam logic [PER_W-1:0] LOW_MARGIN = 12'd50;
  localparam logic [SPD_W-1:0] BASE_RPM   = 14'd1000;

  localparam logic [2:0] REG_MIN_PERIOD   = 3'd0;
  localparam logic [2:0] REG_MAX_PERIOD   = 3'd1;
  localparam logic [2:0] REG_MAX_SPEED    = 3'd2;
  localparam logic [2:0] REG_MOTOR_COUNT  = 3'd3;
  localparam logic [2:0] REG_MOTOR_LAYOUT = 3'd4;

  typedef struct packed {
    logic [PER_W-1:0] period_3;
    logic [PER_W-1:0] period_2;
    logic [PER_W-1:0] period_1;
    logic [PER_W-1:0] period_0;
  } in_req_t;

  typedef struct packed {
    logic [7:0] tx_byte;
    logic       end_of_transfer;
    logic       last;
  } out_res_t;

  // Command handed from the front part to the back part.
  typedef enum logic [1:0] {
    JOB_NONE  = 2'd0,
    JOB_STOP  = 2'd1,
    JOB_FRAME = 2'd2,
    JOB_START = 2'd3
  } job_kind_t;

  typedef struct packed {
    job_kind_t              kind;
    logic [4*SPD_W-1:0]     speeds;
  } job_t;

  typedef enum logic [2:0] {
    FS_IDLE, FS_CHECK, FS_MUL, FS_DIV, FS_STORE, FS_PUSH
  } front_state_t;

  typedef enum logic [1:0] {
    BS_IDLE, BS_SEND
  } back_state_t;

  function automatic logic [1:0] slot_of(input logic layout, input logic [1:0] ch);
    logic [1:0] s;
    case (ch)
      2'd0:    s = layout ? 2'd1 : 2'd0;
      2'd1:    s = layout ? 2'd3 : 2'd2;
      2'd2:    s = layout ? 2'd0 : 2'd1;
      default: s = layout ? 2'd2 : 2'd3;
    endcase
    return s;
  endfunction

endpackage

FILE: src/escf_front.sv
// ----------------------------------------------------------------------------
// escf_front: update classifier and rpm converter
// Checks the channels in order, scales each to rpm with a serial divider,
// tracks the running flag and pushes at most one job per update.
// ----------------------------------------------------------------------------
module escf_front
  import escf_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  in_req_t          in_data,
  input  logic [PER_W-1:0] min_period,
  input  logic [PER_W-1:0] max_period,
  input  logic [SPD_W-1:0] max_speed,
  input  logic [2:0]       motor_count,
  input  logic             motor_layout,
  output logic             job_valid,
  input  logic             job_ready,
  output job_t             job_data
);

  localparam int unsigned PROD_W = PER_W + SPD_W + 1;

  front_state_t              st_r, st_nxt;
  logic [4*PER_W-1:0]        per_r;
  logic [2:0]                ch_r, ch_nxt;
  logic [2:0]                n_eff;
  logic [SPD_W-1:0]          store_r [4];
  logic                      running_r, running_nxt;
  logic                      low_r, low_nxt;
  job_kind_t                 kind_r, kind_nxt;
  logic signed [PROD_W-1:0]  prod_r;
  logic [PROD_W-1:0]         rem_r;
  logic [PROD_W-1:0]         quo_r;
  logic [4:0]                bit_r;
  logic                      neg_r;
  logic [PER_W-1:0]          p_cur, p_clamp, span;
  logic signed [SPD_W:0]     dspd;
  logic [PROD_W:0]           trial;
  logic signed [PROD_W+1:0]  rpm_wide;
  logic [SPD_W-1:0]          rpm;

  assign n_eff  = (motor_count > 3'(MOTORS)) ? 3'(MOTORS) : motor_count;
  assign p_cur  = per_r[ch_r[1:0]*PER_W +: PER_W];
  assign p_clamp = (p_cur < min_period) ? min_period :
                   (p_cur > max_period) ? max_period : p_cur;
  assign span   = max_period - min_period;
  assign dspd   = $signed({1'b0, max_speed}) - $signed({1'b0, BASE_RPM});
  assign trial  = {rem_r, quo_r[PROD_W-1]} - {1'b0, PROD_W'(span)};

  // Signed product divided as a magnitude; truncation toward zero.
  always_comb begin
    rpm_wide = neg_r ? -$signed({2'b00, quo_r}) : $signed({2'b00, quo_r});
    rpm_wide = rpm_wide + $signed((PROD_W+2)'(BASE_RPM));
    if (max_period <= min_period) rpm = BASE_RPM;
    else if (rpm_wide < 0) rpm = '0;
    else if (rpm_wide > 16383) rpm = '1;
    else rpm = rpm_wide[SPD_W-1:0];
  end

  always_comb begin
    st_nxt      = st_r;
    ch_nxt      = ch_r;
    running_nxt = running_r;
    low_nxt     = low_r;
    kind_nxt    = kind_r;
    in_ready    = (st_r == FS_IDLE);
    job_valid   = 1'b0;
    case (st_r)
      FS_IDLE: begin
        if (in_valid) begin
          st_nxt  = FS_CHECK;
          ch_nxt  = '0;
          low_nxt = 1'b0;
        end
      end
      FS_CHECK: begin
        if (ch_r >= n_eff) begin
          st_nxt = FS_PUSH;
        end else if ({1'b0, p_cur} <= {1'b0, min_period} + {1'b0, LOW_MARGIN}) begin
          low_nxt = 1'b1;
          st_nxt  = FS_PUSH;
        end else begin
          st_nxt = FS_MUL;
        end
        if (st_nxt == FS_PUSH) begin
          if (low_nxt) begin
            kind_nxt    = running_r ? JOB_STOP : JOB_NONE;
            running_nxt = 1'b0;
          end else begin
            kind_nxt    = running_r ? JOB_FRAME : JOB_START;
            running_nxt = 1'b1;
          end
        end
      end
      FS_MUL:   st_nxt = FS_DIV;
      FS_DIV:   if (bit_r == 5'd0) st_nxt = FS_STORE;
      FS_STORE: begin
        ch_nxt = ch_r + 3'd1;
        st_nxt = FS_CHECK;
      end
      FS_PUSH: begin
        job_valid = (kind_r != JOB_NONE);
        if (kind_r == JOB_NONE || job_ready) st_nxt = FS_IDLE;
      end
      default: st_nxt = FS_IDLE;
    endcase
  end

  assign job_data.kind   = kind_r;
  assign job_data.speeds = {store_r[3], store_r[2], store_r[1], store_r[0]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r      <= FS_IDLE;
      running_r <= 1'b0;
      ch_r      <= '0;
      low_r     <= 1'b0;
      kind_r    <= JOB_NONE;
      for (int i = 0; i < 4; i++) store_r[i] <= '0;
    end else begin
      st_r      <= st_nxt;
      ch_r      <= ch_nxt;
      running_r <= running_nxt;
      low_r     <= low_nxt;
      kind_r    <= kind_nxt;
      if (st_r == FS_STORE) store_r[slot_of(motor_layout, ch_r[1:0])] <= rpm;
    end
  end

  always_ff @(posedge clk) begin
    if (st_r == FS_IDLE && in_valid) per_r <= in_data;
    if (st_r == FS_CHECK) begin
      prod_r <= $signed({1'b0, PER_W'(p_clamp - min_period)}) * dspd;
    end
    if (st_r == FS_MUL) begin
      neg_r <= prod_r[PROD_W-1];
      quo_r <= prod_r[PROD_W-1] ? PROD_W'(-prod_r) : PROD_W'(prod_r);
      rem_r <= '0;
      bit_r <= 5'(PROD_W - 1);
    end
    if (st_r == FS_DIV) begin
      if (!trial[PROD_W]) rem_r <= trial[PROD_W-1:0];
      else rem_r <= {rem_r[PROD_W-2:0], quo_r[PROD_W-1]};
      quo_r <= {quo_r[PROD_W-2:0], ~trial[PROD_W]};
      bit_r <= bit_r - 5'd1;
    end
  end

endmodule

FILE: src/escf_queue.sv
// ----------------------------------------------------------------------------
// escf_queue: two-entry job queue
// Decouples the classifier from the byte sender.
// ----------------------------------------------------------------------------
module escf_queue
  import escf_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic wr_valid,
  output logic wr_ready,
  input  job_t wr_data,
  output logic rd_valid,
  input  logic rd_ready,
  output job_t rd_data
);

  job_t       mem_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;
  logic       push, pop;

  assign wr_ready = (cnt_r != 2'd2);
  assign rd_valid = (cnt_r != 2'd0);
  assign rd_data  = mem_r[rp_r];
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (pop) rp_r <= ~rp_r;
      cnt_r <= cnt_r + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= wr_data;
  end

endmodule

FILE: src/escf_back.sv
// ----------------------------------------------------------------------------
// escf_back: byte sender
// Expands one job into its link bytes, one per cycle unless the link stalls, into an output register.
// ----------------------------------------------------------------------------
module escf_back
  import escf_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     job_valid,
  output logic     job_ready,
  input  job_t     job_data,
  output logic     out_valid,
  input  logic     out_ready,
  output out_res_t out_data
);

  back_state_t st_r, st_nxt;
  job_t        job_r;
  logic [3:0]  idx_r, idx_nxt;
  logic [3:0]  cnt;
  logic [7:0]  sum_r;
  logic        ov_r;
  out_res_t    od_r;
  out_res_t    byt;
  logic        emit;
  logic [3:0]  fi;
  logic [3:0]  fm1;
  logic [SPD_W-1:0] w;

  assign cnt = (job_r.kind == JOB_STOP) ? 4'd2 :
               (job_r.kind == JOB_START) ? 4'd12 : 4'd11;
  assign fi  = (job_r.kind == JOB_START) ? idx_r - 4'd1 : idx_r;
  // Frame bytes 1..8 carry the four speed words, high byte first.
  assign fm1 = fi - 4'd1;
  assign w   = job_r.speeds[fm1[2:1]*SPD_W +: SPD_W];

  always_comb begin
    byt.last = (idx_r == cnt - 4'd1);
    byt.end_of_transfer = 1'b0;
    byt.tx_byte = 8'h00;
    if (job_r.kind == JOB_STOP) begin
      byt.tx_byte = (idx_r == 4'd0) ? CMD_STOP : CMD_CLEAR;
      byt.end_of_transfer = 1'b1;
    end else if (job_r.kind == JOB_START && idx_r == 4'd0) begin
      byt.tx_byte = CMD_START;
      byt.end_of_transfer = 1'b1;
    end else begin
      case (fi)
        4'd0:    byt.tx_byte = CMD_SPEED;
        4'd9:    byt.tx_byte = 8'h00;
        4'd10: begin
          byt.tx_byte = sum_r;
          byt.end_of_transfer = 1'b1;
        end
        default: byt.tx_byte = fi[0] ? 8'(w >> 8) : w[7:0];
      endcase
    end
  end

  assign emit      = (st_r == BS_SEND) && (!ov_r || out_ready);
  assign job_ready = (st_r == BS_IDLE);
  assign out_valid = ov_r;
  assign out_data  = od_r;

  always_comb begin
    st_nxt  = st_r;
    idx_nxt = idx_r;
    case (st_r)
      BS_IDLE: if (job_valid) begin
        st_nxt  = BS_SEND;
        idx_nxt = '0;
      end
      BS_SEND: if (emit) begin
        idx_nxt = idx_r + 4'd1;
        if (byt.last) st_nxt = BS_IDLE;
      end
      default: st_nxt = BS_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r  <= BS_IDLE;
      idx_r <= '0;
      ov_r  <= 1'b0;
    end else begin
      st_r  <= st_nxt;
      idx_r <= idx_nxt;
      if (emit) ov_r <= 1'b1;
      else if (out_ready) ov_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (st_r == BS_IDLE && job_valid) begin
      job_r <= job_data;
      sum_r <= CMD_SPEED;
    end
    if (emit) begin
      od_r <= byt;
      if (job_r.kind != JOB_STOP && fi >= 4'd1 && fi <= 4'd8)
        sum_r <= sum_r ^ byt.tx_byte;
    end
  end

endmodule

FILE: src/esc_speed_command_framer_core.sv
// ----------------------------------------------------------------------------
// esc_speed_command_framer_core: motor speed command framer
// Each update passes the front part's channel checks and its bit-serial rpm
// divider (27 quotient bits, one a cycle) per converted channel before the
// first byte; the front part takes a new update only after handing on the
// last one's job. Bytes then leave at one per cycle while the link takes them.
// Reset (rst_n low, synchronous) restores register defaults, clears the
// speed store and marks the motors stopped.
// ----------------------------------------------------------------------------
module esc_speed_command_framer_core
  import escf_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  in_req_t     in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output out_res_t    out_data,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [4:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  // Configuration registers, written over the APB-style port.
  logic [PER_W-1:0] min_period_r, max_period_r;
  logic [SPD_W-1:0] max_speed_r;
  logic [2:0]       motor_count_r;
  logic             motor_layout_r;
  logic [2:0]       reg_idx;
  logic             wr_en;

  assign cfg_pready = 1'b1;
  assign reg_idx    = cfg_paddr[4:2];
  assign wr_en      = cfg_psel && cfg_penable && cfg_pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_period_r   <= 12'd1100;
      max_period_r   <= 12'd1900;
      max_speed_r    <= 14'd11000;
      motor_count_r  <= 3'd4;
      motor_layout_r <= 1'b1;
    end else if (wr_en && cfg_paddr[1:0] == 2'b00) begin
      case (reg_idx)
        REG_MIN_PERIOD:   min_period_r   <= cfg_pwdata[PER_W-1:0];
        REG_MAX_PERIOD:   max_period_r   <= cfg_pwdata[PER_W-1:0];
        REG_MAX_SPEED:    max_speed_r    <= cfg_pwdata[SPD_W-1:0];
        REG_MOTOR_COUNT:  motor_count_r  <= cfg_pwdata[2:0];
        REG_MOTOR_LAYOUT: motor_layout_r <= cfg_pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_MIN_PERIOD:   cfg_prdata = 32'(min_period_r);
      REG_MAX_PERIOD:   cfg_prdata = 32'(max_period_r);
      REG_MAX_SPEED:    cfg_prdata = 32'(max_speed_r);
      REG_MOTOR_COUNT:  cfg_prdata = 32'(motor_count_r);
      REG_MOTOR_LAYOUT: cfg_prdata = 32'(motor_layout_r);
      default:          cfg_prdata = '0;
    endcase
  end

  // Front part classifies the update and converts speeds; the queue lets
  // it start the next update while the back part is still sending bytes.
  logic job_in_valid, job_in_ready, job_out_valid, job_out_ready;
  job_t job_in, job_out;

  escf_front u_front (
    .clk, .rst_n, .in_valid, .in_ready, .in_data,
    .min_period(min_period_r), .max_period(max_period_r),
    .max_speed(max_speed_r), .motor_count(motor_count_r),
    .motor_layout(motor_layout_r),
    .job_valid(job_in_valid), .job_ready(job_in_ready), .job_data(job_in)
  );

  escf_queue u_queue (
    .clk, .rst_n,
    .wr_valid(job_in_valid), .wr_ready(job_in_ready), .wr_data(job_in),
    .rd_valid(job_out_valid), .rd_ready(job_out_ready), .rd_data(job_out)
  );

  escf_back u_back (
    .clk, .rst_n,
    .job_valid(job_out_valid), .job_ready(job_out_ready), .job_data(job_out),
    .out_valid, .out_ready, .out_data
  );

endmodule

FILE: sim/escf_checker.sv
// ----------------------------------------------------------------------------
// escf_checker: scoreboard of the speed command framer
// Watches the request and result channels and the register port, predicts
// the byte stream from its own copy of the state and compares each byte.
// ----------------------------------------------------------------------------
module escf_checker
  import escf_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  in_req_t     in_data,
  input  logic        out_valid,
  input  logic        out_ready,
  input  out_res_t    out_data,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [4:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output int          fail_count,
  output int          pending,
  output int          bytes_seen
);

  logic [11:0] min_p, max_p;
  logic [13:0] top_speed;
  logic [2:0]  active_cnt;
  logic        layout;
  logic        spinning;
  logic [13:0] speeds [4];
  out_res_t    byte_queue [$];

  function automatic logic [13:0] rpm_of(input logic [11:0] p);
    longint lo, hi, v, r;
    lo = min_p;
    hi = max_p;
    v = p;
    if (hi <= lo) return BASE_RPM;
    if (v < lo) v = lo;
    else if (v > hi) v = hi;
    r = ((v - lo) * (longint'(top_speed) - 1000)) / (hi - lo) + 1000;
    if (r < 0) r = 0;
    if (r > 16383) r = 16383;
    return r[13:0];
  endfunction

  task automatic queue_byte(input logic [7:0] b, input logic eot);
    out_res_t r;
    r.tx_byte = b;
    r.end_of_transfer = eot;
    r.last = 1'b0;
    byte_queue.push_back(r);
  endtask

  task automatic frame_update(input in_req_t req);
    int n, added;
    logic low;
    logic [11:0] p, ch [4];
    logic [7:0] sum;
    n = (active_cnt > 4) ? 4 : active_cnt;
    added = byte_queue.size();
    low = 1'b0;
    ch[0] = req.period_0; ch[1] = req.period_1;
    ch[2] = req.period_2; ch[3] = req.period_3;
    for (int i = 0; i < n; i++) begin
      p = ch[i];
      if ({1'b0, p} <= {1'b0, min_p} + 13'd50) begin
        low = 1'b1;
        break;
      end
      speeds[slot_of(layout, i[1:0])] = rpm_of(p);
    end
    if (low) begin
      if (spinning) begin
        queue_byte(CMD_STOP, 1'b1);
        queue_byte(CMD_CLEAR, 1'b1);
        spinning = 1'b0;
      end
    end else begin
      if (!spinning) begin
        queue_byte(CMD_START, 1'b1);
        spinning = 1'b1;
      end
      sum = CMD_SPEED;
      queue_byte(CMD_SPEED, 1'b0);
      for (int i = 0; i < 4; i++) begin
        queue_byte({2'b00, speeds[i][13:8]}, 1'b0);
        queue_byte(speeds[i][7:0], 1'b0);
        sum ^= {2'b00, speeds[i][13:8]} ^ speeds[i][7:0];
      end
      queue_byte(8'h00, 1'b0);
      queue_byte(sum, 1'b1);
    end
    if (byte_queue.size() > added) byte_queue[$].last = 1'b1;
  endtask

  assign pending = byte_queue.size();

  always @(posedge clk) begin
    out_res_t want;
    if (!rst_n) begin
      min_p <= 12'd1100; max_p <= 12'd1900; top_speed <= 14'd11000;
      active_cnt <= 3'd4; layout <= 1'b1; spinning = 1'b0;
      for (int i = 0; i < 4; i++) speeds[i] = '0;
      byte_queue.delete();
      fail_count <= 0;
      bytes_seen <= 0;
    end else begin
      if (out_valid && out_ready) begin
        bytes_seen <= bytes_seen + 1;
        if (byte_queue.size() == 0) begin
          if (fail_count < 10) $display("unexpected byte %h", out_data);
          fail_count <= fail_count + 1;
        end else begin
          want = byte_queue.pop_front();
          if (want !== out_data) begin
            if (fail_count < 10)
              $display("byte mismatch: expected %h/%b/%b got %h/%b/%b",
                       want.tx_byte, want.end_of_transfer, want.last,
                       out_data.tx_byte, out_data.end_of_transfer, out_data.last);
            fail_count <= fail_count + 1;
          end
        end
      end
      if (in_valid && in_ready) frame_update(in_data);
      if (cfg_psel && cfg_penable && cfg_pwrite) begin
        case (cfg_paddr[4:2])
          REG_MIN_PERIOD:   min_p <= cfg_pwdata[11:0];
          REG_MAX_PERIOD:   max_p <= cfg_pwdata[11:0];
          REG_MAX_SPEED:    top_speed <= cfg_pwdata[13:0];
          REG_MOTOR_COUNT:  active_cnt <= cfg_pwdata[2:0];
          REG_MOTOR_LAYOUT: layout <= cfg_pwdata[0];
          default: ;
        endcase
      end
    end
  end

endmodule

FILE: sim/tb_esc_speed_command_framer_core.sv
// ----------------------------------------------------------------------------
// tb_esc_speed_command_framer_core: testbench of the speed command framer
// Drives period updates under several register settings and idle patterns;
// the checker predicts and compares every byte on the link.
// ----------------------------------------------------------------------------
module tb_esc_speed_command_framer_core;
  import escf_pkg::*;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  in_req_t     in_data;
  logic        out_valid;
  logic        out_ready;
  out_res_t    out_data;
  logic        cfg_psel, cfg_penable, cfg_pwrite;
  logic [4:0]  cfg_paddr;
  logic [31:0] cfg_pwdata, cfg_prdata;
  logic        cfg_pready;
  int          fail_count, pending, bytes_seen;
  int          cycles = 0;
  // Percent chances that the sender idles and that the receiver stalls.
  int          send_idle, recv_stall;
  int          requests_sent;

  localparam int CYCLE_LIMIT = 1500000;

  esc_speed_command_framer_core i_dut (.*);

  escf_checker i_checker (
    .clk, .rst_n, .in_valid, .in_ready, .in_data, .out_valid, .out_ready,
    .out_data, .cfg_psel, .cfg_penable, .cfg_pwrite, .cfg_paddr, .cfg_pwdata,
    .fail_count, .pending, .bytes_seen
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // The receiver stalls at random; the rate is changed per phase.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall);
    end
  end

  // The watchdog ends a run that hangs.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("== FAIL ==");
      $finish;
    end
  end

  // A register write is a setup phase followed by an access phase. It is
  // only issued while the block is idle.
  task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
    @(posedge clk);
    cfg_psel <= 1'b1; cfg_penable <= 1'b0; cfg_pwrite <= 1'b1;
    cfg_paddr <= {idx, 2'b00}; cfg_pwdata <= val;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel <= 1'b0; cfg_penable <= 1'b0; cfg_pwrite <= 1'b0;
  endtask

  // Waits until every predicted byte has left, then lets the front part
  // finish an update that caused no bytes (up to four divider passes).
  task automatic drain;
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  task automatic set_registers(input int lo, input int hi, input int spd,
                               input int cnt, input int lay);
    drain();
    write_reg(REG_MIN_PERIOD, lo);
    write_reg(REG_MAX_PERIOD, hi);
    write_reg(REG_MAX_SPEED, spd);
    write_reg(REG_MOTOR_COUNT, cnt);
    write_reg(REG_MOTOR_LAYOUT, lay);
  endtask

  // Offers one request and holds it until it is accepted. Valid is left
  // high afterwards, so a request that directly follows keeps it high;
  // idling and waiting lower it.
  task automatic send_update(input in_req_t req);
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= req;
    @(negedge clk);
    while (!in_ready) @(negedge clk);
    @(posedge clk);
    requests_sent++;
  endtask

  task automatic send_all(input logic [11:0] p);
    send_update('{p, p, p, p});
  endtask

  // Mostly periods above the low threshold, with some low ones and some
  // saturating ones, so that start, stop and frames all occur.
  function automatic logic [11:0] pick_period(input int lo, input int hi);
    int r;
    r = $urandom_range(99);
    if (r < 8) return 12'($urandom_range(4095));
    if (r < 16) return 12'($urandom_range(lo + 50));
    if (r < 22) return 12'hFFF;
    return 12'($urandom_range((hi > lo + 51 ? hi : lo + 51) + 100, lo + 51));
  endfunction

  task automatic random_phase(input int count, input int lo, input int hi);
    in_req_t req;
    for (int i = 0; i < count; i++) begin
      req.period_0 = pick_period(lo, hi);
      req.period_1 = pick_period(lo, hi);
      req.period_2 = pick_period(lo, hi);
      req.period_3 = pick_period(lo, hi);
      send_update(req);
      // Once per phase, hold back until all predicted bytes have come.
      if (i == count / 2) begin
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
      end
    end
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    cfg_psel = 1'b0; cfg_penable = 1'b0; cfg_pwrite = 1'b0;
    cfg_paddr = '0; cfg_pwdata = '0;
    send_idle = 0; recv_stall = 0;
    requests_sent = 0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part at reset settings: low while stopped, start, full
    // scale, saturation, the threshold edge, stop, and a partial update.
    send_all(12'd0);
    send_all(12'd1151);
    send_all(12'd4095);
    send_all(12'd1900);
    send_all(12'd1150);
    send_all(12'd1150);
    send_update('{12'd1500, 12'd1200, 12'd1100, 12'd2000});
    send_update('{12'd0, 12'd1300, 12'd1700, 12'd1800});
    send_all(12'hAAA);
    send_all(12'h555);
    send_update('{12'd1161, 12'd1151, 12'd1900, 12'd1901});

    // Empty period range, low max speed and zero motors.
    set_registers(2000, 1000, 500, 0, 0);
    send_all(12'd0);
    send_all(12'd2100);
    set_registers(500, 501, 1001, 7, 0);
    send_all(12'd551);
    send_all(12'd4095);
    send_all(12'd550);
    set_registers(2500, 2501, 16383, 1, 1);
    send_update('{12'd0, 12'd0, 12'd0, 12'd2600});
    send_update('{12'd2600, 12'd0, 12'd0, 12'd0});
    send_update('{12'd2501, 12'd0, 12'd0, 12'd0});

    // Random phases: idle patterns crossed with register settings.
    set_registers(1100, 1900, 11000, 4, 1);
    random_phase(80, 1100, 1900);
    set_registers(500, 2501, 16383, 4, 0);
    send_idle = 64;
    random_phase(70, 500, 2501);
    set_registers(1000, 2000, 1001, 3, 1);
    send_idle = 0; recv_stall = 64;
    random_phase(70, 1000, 2000);
    set_registers(2500, 2501, 16383, 2, 0);
    send_idle = 7; recv_stall = 7;
    random_phase(70, 2500, 2501);
    set_registers(900, 2200, 7000, 4, 1);
    send_idle = 0; recv_stall = 0;
    random_phase(70, 900, 2200);

    drain();
    $display("%0d updates sent, %0d link bytes checked over nine register settings",
             requests_sent, bytes_seen);
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("%0d mismatches", fail_count);
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

FILE: files.f
src/escf_pkg.sv
src/escf_front.sv
src/escf_queue.sv
src/escf_back.sv
src/esc_speed_command_framer_core.sv
sim/escf_checker.sv
sim/tb_esc_speed_command_framer_core.sv
